FILE: hw/rtl/vmrp_pkg.sv
// Package: shared types, register offsets and codes for the video register write port.
`timescale 1ns / 1ps

package vmrp_pkg;

    localparam logic [5:0] FUNC_DISP       = 6'h00;
    localparam logic [5:0] FUNC_OAM_ADDR_L = 6'h02;
    localparam logic [5:0] FUNC_OAM_ADDR_H = 6'h03;
    localparam logic [5:0] FUNC_OAM_DATA   = 6'h04;
    localparam logic [5:0] FUNC_VRAM_MODE  = 6'h15;
    localparam logic [5:0] FUNC_VRAM_ADDR_L = 6'h16;
    localparam logic [5:0] FUNC_VRAM_ADDR_H = 6'h17;
    localparam logic [5:0] FUNC_VRAM_DATA_L = 6'h18;
    localparam logic [5:0] FUNC_VRAM_DATA_H = 6'h19;
    localparam logic [5:0] FUNC_PAL_ADDR   = 6'h21;
    localparam logic [5:0] FUNC_PAL_DATA   = 6'h22;
    localparam logic [5:0] FUNC_FIXED      = 6'h32;

    localparam logic [1:0] TGT_VRAM  = 2'd0;
    localparam logic [1:0] TGT_OAM   = 2'd1;
    localparam logic [1:0] TGT_CGRAM = 2'd2;

    localparam logic [1:0] MASK_NONE = 2'd0;
    localparam logic [1:0] MASK_LOW  = 2'd1;
    localparam logic [1:0] MASK_HIGH = 2'd2;
    localparam logic [1:0] MASK_PAIR = 2'd3;

    localparam logic [1:0] REMAP_NONE = 2'd0;
    localparam logic [1:0] REMAP_8    = 2'd1;
    localparam logic [1:0] REMAP_9    = 2'd2;
    localparam logic [1:0] REMAP_10   = 2'd3;

    localparam logic [1:0] INC_1  = 2'd0;
    localparam logic [1:0] INC_32 = 2'd1;

    localparam logic [7:0] STEP_1   = 8'd1;
    localparam logic [7:0] STEP_32  = 8'd32;
    localparam logic [7:0] STEP_128 = 8'd128;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DISP,
        OP_OAM_ADDR_L,
        OP_OAM_ADDR_H,
        OP_OAM_DATA,
        OP_VRAM_MODE,
        OP_VRAM_ADDR_L,
        OP_VRAM_ADDR_H,
        OP_VRAM_DATA_L,
        OP_VRAM_DATA_H,
        OP_PAL_ADDR,
        OP_PAL_DATA,
        OP_FIXED
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic        full;
        logic        empty;
    } q_status_t;

    typedef struct packed {
        logic        write_valid;
        logic [1:0]  target;
        logic [15:0] mem_addr;
        logic [7:0]  data_low;
        logic [7:0]  data_high;
        logic [1:0]  byte_mask;
        logic [14:0] fixed_color;
        logic [3:0]  brightness;
        logic        forced_blank;
    } res_t;

endpackage

FILE: hw/rtl/vmrp_if.sv
// Interfaces: request and response channels of the video register write port.
`timescale 1ns / 1ps

interface vmrp_req_if;
    logic       valid;
    logic       ready;
    logic [5:0] func;
    logic [7:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface vmrp_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [1:0]  target;
    logic [15:0] mem_addr;
    logic [7:0]  data_low;
    logic [7:0]  data_high;
    logic [1:0]  byte_mask;
    logic [14:0] fixed_color;
    logic [3:0]  brightness;
    logic        forced_blank;

    modport source (
        output valid, output write_valid, output target, output mem_addr,
        output data_low, output data_high, output byte_mask, output fixed_color,
        output brightness, output forced_blank, input ready
    );
    modport sink (
        input valid, input write_valid, input target, input mem_addr,
        input data_low, input data_high, input byte_mask, input fixed_color,
        input brightness, input forced_blank, output ready
    );
endinterface

FILE: hw/rtl/vmrp_front.sv
// Front end: classify a register write by offset into a command.
`timescale 1ns / 1ps

module vmrp_front (
    input  logic [5:0]    func,
    input  logic [7:0]    value,
    output vmrp_pkg::cmd_t cmd
);

    always_comb
    begin
        cmd.value = value;
        case (func)
            vmrp_pkg::FUNC_DISP:        cmd.op = vmrp_pkg::OP_DISP;
            vmrp_pkg::FUNC_OAM_ADDR_L:  cmd.op = vmrp_pkg::OP_OAM_ADDR_L;
            vmrp_pkg::FUNC_OAM_ADDR_H:  cmd.op = vmrp_pkg::OP_OAM_ADDR_H;
            vmrp_pkg::FUNC_OAM_DATA:    cmd.op = vmrp_pkg::OP_OAM_DATA;
            vmrp_pkg::FUNC_VRAM_MODE:   cmd.op = vmrp_pkg::OP_VRAM_MODE;
            vmrp_pkg::FUNC_VRAM_ADDR_L: cmd.op = vmrp_pkg::OP_VRAM_ADDR_L;
            vmrp_pkg::FUNC_VRAM_ADDR_H: cmd.op = vmrp_pkg::OP_VRAM_ADDR_H;
            vmrp_pkg::FUNC_VRAM_DATA_L: cmd.op = vmrp_pkg::OP_VRAM_DATA_L;
            vmrp_pkg::FUNC_VRAM_DATA_H: cmd.op = vmrp_pkg::OP_VRAM_DATA_H;
            vmrp_pkg::FUNC_PAL_ADDR:    cmd.op = vmrp_pkg::OP_PAL_ADDR;
            vmrp_pkg::FUNC_PAL_DATA:    cmd.op = vmrp_pkg::OP_PAL_DATA;
            vmrp_pkg::FUNC_FIXED:       cmd.op = vmrp_pkg::OP_FIXED;
            default:                    cmd.op = vmrp_pkg::OP_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/vmrp_queue.sv
// Command queue: short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module vmrp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vmrp_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output vmrp_pkg::cmd_t       head,
    output vmrp_pkg::q_status_t  status
);

    vmrp_pkg::cmd_t          mem_reg [vmrp_pkg::QDEPTH];
    logic [vmrp_pkg::QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vmrp_pkg::QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vmrp_pkg::QAW:0]   count_reg, count_next;

    localparam logic [vmrp_pkg::QAW:0]   FULL_COUNT = (vmrp_pkg::QAW+1)'(vmrp_pkg::QDEPTH);
    localparam logic [vmrp_pkg::QAW-1:0] LAST_PTR   = vmrp_pkg::QAW'(vmrp_pkg::QDEPTH - 1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

FILE: hw/rtl/vmrp_back.sv
// Back end: register state, execute commands and hold the response register.
`timescale 1ns / 1ps

module vmrp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vmrp_pkg::cmd_t  head,
    input  logic            head_valid,
    output logic            pop,
    output vmrp_pkg::res_t  res,
    output logic            rsp_valid,
    input  logic            rsp_ready
);

    logic [8:0]  oam_word_reg, oam_word_next;
    logic [9:0]  oam_byte_reg, oam_byte_next;
    logic [7:0]  oam_buf_reg, oam_buf_next;
    logic [14:0] vram_word_reg, vram_word_next;
    logic [7:0]  vram_step_reg, vram_step_next;
    logic [1:0]  vram_remap_reg, vram_remap_next;
    logic        step_high_reg, step_high_next;
    logic [7:0]  pal_addr_reg, pal_addr_next;
    logic [7:0]  pal_latch_reg, pal_latch_next;
    logic        pal_second_reg, pal_second_next;
    logic [14:0] fixed_reg, fixed_next;
    logic [3:0]  bright_reg, bright_next;
    logic        blank_reg, blank_next;
    logic        rsp_valid_reg, rsp_valid_next;
    vmrp_pkg::res_t res_reg, res_next;

    logic [14:0] remap_word;
    logic [14:0] vram_stepped;
    logic [7:0]  v;

    function automatic logic [14:0] remap(input logic [14:0] a, input logic [1:0] mode);
        logic [14:0] r;
        case (mode)
            vmrp_pkg::REMAP_8:  r = {a[14:8], a[4:0], a[7:5]};
            vmrp_pkg::REMAP_9:  r = {a[14:9], a[5:0], a[8:6]};
            vmrp_pkg::REMAP_10: r = {a[14:10], a[6:0], a[9:7]};
            default:            r = a;
        endcase
        return r;
    endfunction

    assign v            = head.value;
    assign remap_word   = remap(vram_word_reg, vram_remap_reg);
    assign vram_stepped = vram_word_reg + {7'd0, vram_step_reg};
    assign pop          = head_valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        oam_word_next   = oam_word_reg;
        oam_byte_next   = oam_byte_reg;
        oam_buf_next    = oam_buf_reg;
        vram_word_next  = vram_word_reg;
        vram_step_next  = vram_step_reg;
        vram_remap_next = vram_remap_reg;
        step_high_next  = step_high_reg;
        pal_addr_next   = pal_addr_reg;
        pal_latch_next  = pal_latch_reg;
        pal_second_next = pal_second_reg;
        fixed_next      = fixed_reg;
        bright_next     = bright_reg;
        blank_next      = blank_reg;
        res_next        = '0;

        case (head.op)
            vmrp_pkg::OP_DISP:
            begin
                blank_next  = v[7];
                bright_next = v[3:0];
            end
            vmrp_pkg::OP_OAM_ADDR_L:
            begin
                oam_word_next = {oam_word_reg[8], v};
                oam_byte_next = {oam_word_reg[8], v, 1'b0};
            end
            vmrp_pkg::OP_OAM_ADDR_H:
            begin
                oam_word_next = {v[0], oam_word_reg[7:0]};
                oam_byte_next = {v[0], oam_word_reg[7:0], 1'b0};
            end
            vmrp_pkg::OP_OAM_DATA:
            begin
                if (!oam_byte_reg[9])
                begin
                    if (oam_byte_reg[0])
                    begin
                        res_next.write_valid  = 1'b1;
                        res_next.target       = vmrp_pkg::TGT_OAM;
                        res_next.mem_addr     = {6'd0, oam_byte_reg[9:1], 1'b0};
                        res_next.data_low     = oam_buf_reg;
                        res_next.data_high    = v;
                        res_next.byte_mask    = vmrp_pkg::MASK_PAIR;
                    end
                    else
                    begin
                        oam_buf_next = v;
                    end
                end
                else
                begin
                    if (!oam_byte_reg[0])
                    begin
                        oam_buf_next = v;
                    end
                    res_next.write_valid  = 1'b1;
                    res_next.target       = vmrp_pkg::TGT_OAM;
                    res_next.mem_addr     = {11'h010, oam_byte_reg[4:0]};
                    res_next.data_low     = v;
                    res_next.byte_mask    = vmrp_pkg::MASK_LOW;
                end
                oam_byte_next = oam_byte_reg + 1'b1;
            end
            vmrp_pkg::OP_VRAM_MODE:
            begin
                case (v[1:0])
                    vmrp_pkg::INC_1:  vram_step_next = vmrp_pkg::STEP_1;
                    vmrp_pkg::INC_32: vram_step_next = vmrp_pkg::STEP_32;
                    default:          vram_step_next = vmrp_pkg::STEP_128;
                endcase
                vram_remap_next = v[3:2];
                step_high_next  = v[7];
            end
            vmrp_pkg::OP_VRAM_ADDR_L:
            begin
                vram_word_next = {vram_word_reg[14:8], v};
            end
            vmrp_pkg::OP_VRAM_ADDR_H:
            begin
                vram_word_next = {v[6:0], vram_word_reg[7:0]};
            end
            vmrp_pkg::OP_VRAM_DATA_L:
            begin
                res_next.write_valid  = 1'b1;
                res_next.target       = vmrp_pkg::TGT_VRAM;
                res_next.mem_addr     = {remap_word, 1'b0};
                res_next.data_low     = v;
                res_next.byte_mask    = vmrp_pkg::MASK_LOW;
                if (!step_high_reg)
                begin
                    vram_word_next = vram_stepped;
                end
            end
            vmrp_pkg::OP_VRAM_DATA_H:
            begin
                res_next.write_valid  = 1'b1;
                res_next.target       = vmrp_pkg::TGT_VRAM;
                res_next.mem_addr     = {remap_word, 1'b0};
                res_next.data_high    = v;
                res_next.byte_mask    = vmrp_pkg::MASK_HIGH;
                if (step_high_reg)
                begin
                    vram_word_next = vram_stepped;
                end
            end
            vmrp_pkg::OP_PAL_ADDR:
            begin
                pal_addr_next   = v;
                pal_second_next = 1'b0;
            end
            vmrp_pkg::OP_PAL_DATA:
            begin
                if (!pal_second_reg)
                begin
                    pal_latch_next  = v;
                    pal_second_next = 1'b1;
                end
                else
                begin
                    res_next.write_valid  = 1'b1;
                    res_next.target       = vmrp_pkg::TGT_CGRAM;
                    res_next.mem_addr     = {7'd0, pal_addr_reg, 1'b0};
                    res_next.data_low     = pal_latch_reg;
                    res_next.data_high    = {1'b0, v[6:0]};
                    res_next.byte_mask    = vmrp_pkg::MASK_PAIR;
                    pal_addr_next         = pal_addr_reg + 1'b1;
                    pal_second_next       = 1'b0;
                end
            end
            vmrp_pkg::OP_FIXED:
            begin
                fixed_next = {v[7] ? v[4:0] : fixed_reg[14:10],
                              v[6] ? v[4:0] : fixed_reg[9:5],
                              v[5] ? v[4:0] : fixed_reg[4:0]};
            end
            default:
            begin
                res_next.write_valid = 1'b0;
            end
        endcase

        res_next.fixed_color  = fixed_next;
        res_next.brightness   = bright_next;
        res_next.forced_blank = blank_next;

        if (pop)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oam_word_reg   <= '0;
            oam_byte_reg   <= '0;
            oam_buf_reg    <= '0;
            vram_word_reg  <= '0;
            vram_step_reg  <= vmrp_pkg::STEP_1;
            vram_remap_reg <= vmrp_pkg::REMAP_NONE;
            step_high_reg  <= 1'b0;
            pal_addr_reg   <= '0;
            pal_latch_reg  <= '0;
            pal_second_reg <= 1'b0;
            fixed_reg      <= '0;
            bright_reg     <= '0;
            blank_reg      <= 1'b1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (pop)
            begin
                oam_word_reg   <= oam_word_next;
                oam_byte_reg   <= oam_byte_next;
                oam_buf_reg    <= oam_buf_next;
                vram_word_reg  <= vram_word_next;
                vram_step_reg  <= vram_step_next;
                vram_remap_reg <= vram_remap_next;
                step_high_reg  <= step_high_next;
                pal_addr_reg   <= pal_addr_next;
                pal_latch_reg  <= pal_latch_next;
                pal_second_reg <= pal_second_next;
                fixed_reg      <= fixed_next;
                bright_reg     <= bright_next;
                blank_reg      <= blank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign rsp_valid = rsp_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp_valid_reg)
        else $error("response not loaded after pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (res_reg.write_valid == (res_reg.byte_mask != vmrp_pkg::MASK_NONE)))
        else $error("byte mask disagrees with write flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !res_reg.write_valid) |->
            (res_reg.mem_addr == '0 && res_reg.target == vmrp_pkg::TGT_VRAM))
        else $error("idle response carries an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.op == vmrp_pkg::OP_PAL_DATA) |=>
            (pal_second_reg != $past(pal_second_reg)))
        else $error("palette pairing flag did not toggle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && res_reg.target == vmrp_pkg::TGT_CGRAM) |-> !res_reg.data_high[7])
        else $error("palette high byte bit 7 set");

endmodule

FILE: hw/rtl/video_memory_register_port.sv
// Top level: video register write port, front end, command queue and back end.
//
//  channel | modport | payload                                           | transfer
//  req     | sink    | func, value                                       | valid & ready
//  rsp     | source  | write_valid, target, mem_addr, data_low,          | valid & ready
//          |         | data_high, byte_mask, fixed_color, brightness,    |
//          |         | forced_blank                                      |
//
//  One request per cycle sustained while rsp.ready stays high; a response becomes valid
//  once its request has passed the queue write and then the response register load.
//  The back end executes one command per cycle when the response register is free or taken.
//  req.ready drops only when the two-entry command queue is full.
//  Reset (rst_n low, asynchronous) empties the queue and restores all video state.
`timescale 1ns / 1ps

module video_memory_register_port (
    input  logic        clk,
    input  logic        rst_n,
    vmrp_req_if.sink    req,
    vmrp_rsp_if.source  rsp
);

    vmrp_pkg::cmd_t      front_cmd;
    vmrp_pkg::cmd_t      head;
    vmrp_pkg::q_status_t q_status;
    vmrp_pkg::res_t      res;
    logic                push;
    logic                pop;

    vmrp_front u_front (
        .func  (req.func),
        .value (req.value),
        .cmd   (front_cmd)
    );

    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full;

    vmrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    vmrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_status.empty),
        .pop        (pop),
        .res        (res),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready)
    );

    assign rsp.write_valid  = res.write_valid;
    assign rsp.target       = res.target;
    assign rsp.mem_addr     = res.mem_addr;
    assign rsp.data_low     = res.data_low;
    assign rsp.data_high    = res.data_high;
    assign rsp.byte_mask    = res.byte_mask;
    assign rsp.fixed_color  = res.fixed_color;
    assign rsp.brightness   = res.brightness;
    assign rsp.forced_blank = res.forced_blank;

endmodule

FILE: bench/video_memory_register_port_tb.sv
// Testbench: random and directed register writes against a scoreboard of expected memory writes.
`timescale 1ns / 1ps

module video_memory_register_port_tb;

    import vmrp_pkg::*;

    class video_write_scoreboard;
        logic [8:0]  oam_word;
        logic [9:0]  oam_byte;
        logic [7:0]  oam_buffer;
        logic        oam_rotation;
        logic [14:0] vram_word;
        logic [7:0]  vram_step;
        logic [1:0]  vram_remap;
        logic        vram_step_on_high;
        logic [7:0]  palette_addr;
        logic [7:0]  palette_latch;
        logic        palette_second;
        logic [14:0] fixed_color;
        logic [3:0]  brightness;
        logic        forced_blank;
        res_t        pending_writes[$];
        int          errors;
        int          checked;
        int          memory_writes;

        function void clear_state();
            oam_word          = '0;
            oam_byte          = '0;
            oam_buffer        = '0;
            oam_rotation      = 1'b0;
            vram_word         = '0;
            vram_step         = STEP_1;
            vram_remap        = REMAP_NONE;
            vram_step_on_high = 1'b0;
            palette_addr      = '0;
            palette_latch     = '0;
            palette_second    = 1'b0;
            fixed_color       = '0;
            brightness        = '0;
            forced_blank      = 1'b1;
            pending_writes.delete();
            errors            = 0;
            checked           = 0;
            memory_writes     = 0;
        endfunction

        function logic [14:0] remapped_word();
            case (vram_remap)
                REMAP_8:  return {vram_word[14:8], vram_word[4:0], vram_word[7:5]};
                REMAP_9:  return {vram_word[14:9], vram_word[5:0], vram_word[8:6]};
                REMAP_10: return {vram_word[14:10], vram_word[6:0], vram_word[9:7]};
                default:  return vram_word;
            endcase
        endfunction

        function void note_register_write(logic [5:0] func, logic [7:0] value);
            res_t       w;
            logic [9:0] a;
            w = '0;
            case (func)
                FUNC_DISP:
                begin
                    forced_blank = value[7];
                    brightness   = value[3:0];
                end
                FUNC_OAM_ADDR_L:
                begin
                    oam_word = {oam_word[8], value};
                    oam_byte = {oam_word, 1'b0};
                end
                FUNC_OAM_ADDR_H:
                begin
                    oam_word     = {value[0], oam_word[7:0]};
                    oam_rotation = value[7];
                    oam_byte     = {oam_word, 1'b0};
                end
                FUNC_OAM_DATA:
                begin
                    a = oam_byte;
                    if (!a[9])
                    begin
                        if (a[0])
                        begin
                            w.write_valid  = 1'b1;
                            w.target       = TGT_OAM;
                            w.mem_addr     = {6'd0, a - 10'd1};
                            w.data_low     = oam_buffer;
                            w.data_high    = value;
                            w.byte_mask    = MASK_PAIR;
                        end
                        else
                        begin
                            oam_buffer = value;
                        end
                    end
                    else
                    begin
                        if (!a[0])
                            oam_buffer = value;
                        w.write_valid  = 1'b1;
                        w.target       = TGT_OAM;
                        w.mem_addr     = 16'h0200 | {11'd0, a[4:0]};
                        w.data_low     = value;
                        w.byte_mask    = MASK_LOW;
                    end
                    oam_byte = a + 10'd1;
                end
                FUNC_VRAM_MODE:
                begin
                    case (value[1:0])
                        INC_1:   vram_step = STEP_1;
                        INC_32:  vram_step = STEP_32;
                        default: vram_step = STEP_128;
                    endcase
                    vram_remap        = value[3:2];
                    vram_step_on_high = value[7];
                end
                FUNC_VRAM_ADDR_L: vram_word[7:0]  = value;
                FUNC_VRAM_ADDR_H: vram_word[14:8] = value[6:0];
                FUNC_VRAM_DATA_L:
                begin
                    w.write_valid  = 1'b1;
                    w.target       = TGT_VRAM;
                    w.mem_addr     = {remapped_word(), 1'b0};
                    w.data_low     = value;
                    w.byte_mask    = MASK_LOW;
                    if (!vram_step_on_high)
                        vram_word = vram_word + {7'd0, vram_step};
                end
                FUNC_VRAM_DATA_H:
                begin
                    w.write_valid  = 1'b1;
                    w.target       = TGT_VRAM;
                    w.mem_addr     = {remapped_word(), 1'b0};
                    w.data_high    = value;
                    w.byte_mask    = MASK_HIGH;
                    if (vram_step_on_high)
                        vram_word = vram_word + {7'd0, vram_step};
                end
                FUNC_PAL_ADDR:
                begin
                    palette_addr   = value;
                    palette_second = 1'b0;
                end
                FUNC_PAL_DATA:
                begin
                    if (!palette_second)
                    begin
                        palette_latch  = value;
                        palette_second = 1'b1;
                    end
                    else
                    begin
                        w.write_valid  = 1'b1;
                        w.target       = TGT_CGRAM;
                        w.mem_addr     = {7'd0, palette_addr, 1'b0};
                        w.data_low     = palette_latch;
                        w.data_high    = {1'b0, value[6:0]};
                        w.byte_mask    = MASK_PAIR;
                        palette_addr   = palette_addr + 8'd1;
                        palette_second = 1'b0;
                    end
                end
                FUNC_FIXED:
                begin
                    if (value[5])
                        fixed_color[4:0] = value[4:0];
                    if (value[6])
                        fixed_color[9:5] = value[4:0];
                    if (value[7])
                        fixed_color[14:10] = value[4:0];
                end
                default:
                begin
                end
            endcase
            w.fixed_color  = fixed_color;
            w.brightness   = brightness;
            w.forced_blank = forced_blank;
            pending_writes.push_back(w);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_writes.size() == 0)
            begin
                $error("result with no register write pending: write_valid=%0b target=%0d",
                       got.write_valid, got.target);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            checked++;
            if (want.write_valid)
                memory_writes++;
            compare_field("write_valid", 16'(want.write_valid), 16'(got.write_valid));
            compare_field("target", 16'(want.target), 16'(got.target));
            compare_field("mem_addr", want.mem_addr, got.mem_addr);
            compare_field("data_low", 16'(want.data_low), 16'(got.data_low));
            compare_field("data_high", 16'(want.data_high), 16'(got.data_high));
            compare_field("byte_mask", 16'(want.byte_mask), 16'(got.byte_mask));
            compare_field("fixed_color", 16'(want.fixed_color), 16'(got.fixed_color));
            compare_field("brightness", 16'(want.brightness), 16'(got.brightness));
            compare_field("forced_blank", 16'(want.forced_blank), 16'(got.forced_blank));
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycle_count = 0;
    int registers_sent = 0;
    bit drained_midway = 1'b0;
    video_write_scoreboard sb;

    vmrp_req_if req();
    vmrp_rsp_if rsp();

    video_memory_register_port i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_register_write(input logic [5:0] func, input logic [7:0] value);
        int gap;
        gap = pick_gap((cycle_count % 700) < 150);
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid <= 1'b1;
        req.func  <= func;
        req.value <= value;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_register_write(func, value);
        registers_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_register_write(FUNC_DISP, 8'hff);
        send_register_write(FUNC_DISP, 8'h00);
        send_register_write(FUNC_DISP, 8'h8f);
        send_register_write(FUNC_FIXED, 8'hff);
        send_register_write(FUNC_FIXED, 8'h20);
        send_register_write(FUNC_FIXED, 8'h55);
        send_register_write(FUNC_FIXED, 8'h1f);
        send_register_write(FUNC_OAM_ADDR_L, 8'hff);
        send_register_write(FUNC_OAM_ADDR_H, 8'h81);
        send_register_write(FUNC_OAM_DATA, 8'haa);
        send_register_write(FUNC_OAM_DATA, 8'h55);
        send_register_write(FUNC_OAM_DATA, 8'h12);
        send_register_write(FUNC_OAM_DATA, 8'h34);
        send_register_write(FUNC_VRAM_MODE, 8'h8d);
        send_register_write(FUNC_VRAM_ADDR_L, 8'hff);
        send_register_write(FUNC_VRAM_ADDR_H, 8'hff);
        send_register_write(FUNC_VRAM_DATA_L, 8'h00);
        send_register_write(FUNC_VRAM_DATA_H, 8'hff);
        send_register_write(FUNC_VRAM_MODE, 8'h02);
        send_register_write(FUNC_VRAM_DATA_L, 8'h11);
        send_register_write(FUNC_PAL_ADDR, 8'hff);
        send_register_write(FUNC_PAL_DATA, 8'hff);
        send_register_write(FUNC_PAL_DATA, 8'hff);
        send_register_write(FUNC_PAL_DATA, 8'h01);
        send_register_write(FUNC_PAL_ADDR, 8'h10);
        send_register_write(6'h3f, 8'ha5);
        send_register_write(6'h01, 8'h5a);
    endtask

    task automatic run_random();
        int roll;
        int n;
        int order;
        while (registers_sent < 645)
        begin
            if (!drained_midway && registers_sent > 350)
            begin
                hold_until_drained();
                drained_midway = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 25)
            begin
                send_register_write(FUNC_OAM_ADDR_L, 8'($urandom));
                if ($urandom_range(0, 3) != 0)
                    send_register_write(FUNC_OAM_ADDR_H, 8'($urandom));
                n = $urandom_range(1, 10);
                repeat (n) send_register_write(FUNC_OAM_DATA, 8'($urandom));
            end
            else if (roll < 50)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_register_write(FUNC_VRAM_MODE, 8'($urandom));
                send_register_write(FUNC_VRAM_ADDR_L, 8'($urandom));
                send_register_write(FUNC_VRAM_ADDR_H, 8'($urandom));
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    order = $urandom_range(0, 9);
                    if (order != 9)
                        send_register_write(FUNC_VRAM_DATA_L, 8'($urandom));
                    if (order != 8)
                        send_register_write(FUNC_VRAM_DATA_H, 8'($urandom));
                end
            end
            else if (roll < 70)
            begin
                send_register_write(FUNC_PAL_ADDR, 8'($urandom));
                n = $urandom_range(1, 13);
                repeat (n) send_register_write(FUNC_PAL_DATA, 8'($urandom));
            end
            else if (roll < 78)
            begin
                send_register_write(FUNC_DISP, 8'($urandom));
            end
            else if (roll < 86)
            begin
                send_register_write(FUNC_FIXED, 8'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_register_write(6'($urandom_range(0, 63)), 8'($urandom));
            end
        end
    endtask

    initial
    begin : result_taker
        int stall;
        stall = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap((cycle_count % 500) < 120);
                rsp.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.write_valid  = rsp.write_valid;
            got.target       = rsp.target;
            got.mem_addr     = rsp.mem_addr;
            got.data_low     = rsp.data_low;
            got.data_high    = rsp.data_high;
            got.byte_mask    = rsp.byte_mask;
            got.fixed_color  = rsp.fixed_color;
            got.brightness   = rsp.brightness;
            got.forced_blank = rsp.forced_blank;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        sb = new;
        sb.clear_state();
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.func  = '0;
        req.value = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        hold_until_drained();
        run_random();
        hold_until_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d register writes over all offsets; %0d responses compared.",
                 registers_sent, sb.checked);
        $display("%0d of them carried a VRAM, OAM or CGRAM write.", sb.memory_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
